>>> rtl/core/rdi_pkg.sv
// Shared constants, payload structs and register codes of the ray/disc intersection pipeline.
// No dependencies; compiled first.
package rdi_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 32;
  localparam int NORM_W  = 18;
  localparam int RAD_W   = 31;
  localparam int EPS_W   = 16;
  localparam int IDX_W   = 3;

  localparam int PD_W   = NORM_W + COORD_W;      // normal * direction
  localparam int DEN_W  = PD_W + 2;              // sum of three
  localparam int DIFF_W = COORD_W + 1;           // center - origin
  localparam int PN_W   = NORM_W + DIFF_W;       // normal * difference
  localparam int NUM_W  = PN_W + 2;
  localparam int MAG_W  = NUM_W;
  localparam int Q_W    = COORD_W - 1;           // quotient bits below saturation
  localparam int DIVN_W = MAG_W + FRAC_BITS;     // scaled dividend
  localparam int SAT_W  = MAG_W + Q_W;
  localparam int P_W    = 2 * COORD_W;           // dist * direction
  localparam int H_W    = P_W + 2;               // hit offset
  localparam int AX_W   = COORD_W - 1;
  localparam int SQ_W   = 2 * AX_W;
  localparam int SUM_W  = SQ_W + 2;

  localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_NORMAL_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_NORMAL_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_NORMAL_Z = 3'd5;
  localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd6;
  localparam logic [IDX_W-1:0] REG_EPSILON  = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic [EPS_W-1:0]          edge_epsilon;
    logic [SQ_W-1:0]           radius_sq;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] near_limit;
    logic signed [COORD_W-1:0] best_in;
  } ray_t;

  typedef struct packed {
    logic             valid;
    logic             reject;
    logic             neg;
    logic [MAG_W-1:0] nmag;
    logic [DEN_W-1:0] dmag;
    ray_t             ray;
  } dot_out_t;

  typedef struct packed {
    logic           valid;
    logic           reject;
    logic           neg;
    logic           sat;
    logic [Q_W-1:0] q;
    ray_t           ray;
  } div_out_t;

  // p / 2^FRAC_BITS truncated toward zero
  function automatic logic signed [P_W-1:0] scale_down(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] bias;
    bias = p[P_W-1] ? P_W'((64'd1 << FRAC_BITS) - 64'd1) : '0;
    return (p + bias) >>> FRAC_BITS;
  endfunction

endpackage

>>> rtl/core/rdi_ray_if.sv
// Ray request channel: valid/ready plus the ray fields.
// Depends on rdi_pkg.
interface rdi_ray_if;
  import rdi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] origin_z;
  logic signed [COORD_W-1:0] dir_x;
  logic signed [COORD_W-1:0] dir_y;
  logic signed [COORD_W-1:0] dir_z;
  logic signed [COORD_W-1:0] near_limit;
  logic signed [COORD_W-1:0] best_distance_in;
  modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 near_limit, best_distance_in, input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               near_limit, best_distance_in, output ready);
endinterface

>>> rtl/core/rdi_res_if.sv
// Result channel: valid/ready plus hit flag and best distance.
// Depends on rdi_pkg.
interface rdi_res_if;
  import rdi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [COORD_W-1:0] best_distance_out;
  modport source(output valid, hit, best_distance_out, input ready);
  modport sink(input valid, hit, best_distance_out, output ready);
endinterface

>>> rtl/core/rdi_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on rdi_pkg.
interface rdi_cfg_if;
  import rdi_pkg::*;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   index;
  logic [COORD_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/rdi_dot.sv
// Front stages: normal dot products for denominator and numerator, edge-on test, magnitudes.
// Depends on rdi_pkg.
module rdi_dot (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  rdi_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  rdi_pkg::ray_t    in_ray,
  output rdi_pkg::dot_out_t out
);
  import rdi_pkg::*;

  logic                     a_v, b_v, c_v;
  logic signed [PD_W-1:0]   a_pdx, a_pdy, a_pdz;
  logic signed [DIFF_W-1:0] a_ex, a_ey, a_ez;
  ray_t                     a_ray, b_ray, c_ray;
  logic signed [DEN_W-1:0]  b_den, c_den;
  logic signed [PN_W-1:0]   b_pnx, b_pny, b_pnz;
  logic signed [NUM_W-1:0]  c_num;
  logic [DEN_W-1:0]         dabs;
  logic [MAG_W-1:0]         nabs;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      out.valid <= 1'b0;
    end else if (en) begin
      a_v       <= in_valid;
      b_v       <= a_v;
      c_v       <= b_v;
      out.valid <= c_v;
    end
  end

  always_comb begin
    dabs = c_den[DEN_W-1] ? DEN_W'(-c_den) : DEN_W'(c_den);
    nabs = c_num[NUM_W-1] ? MAG_W'(-c_num) : MAG_W'(c_num);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // A: direction products, center offsets
      a_pdx <= cfg.normal_x * in_ray.dir_x;
      a_pdy <= cfg.normal_y * in_ray.dir_y;
      a_pdz <= cfg.normal_z * in_ray.dir_z;
      a_ex  <= DIFF_W'(cfg.center_x) - DIFF_W'(in_ray.origin_x);
      a_ey  <= DIFF_W'(cfg.center_y) - DIFF_W'(in_ray.origin_y);
      a_ez  <= DIFF_W'(cfg.center_z) - DIFF_W'(in_ray.origin_z);
      a_ray <= in_ray;
      // B: denominator sum, numerator products
      b_den <= DEN_W'(a_pdx) + DEN_W'(a_pdy) + DEN_W'(a_pdz);
      b_pnx <= cfg.normal_x * a_ex;
      b_pny <= cfg.normal_y * a_ey;
      b_pnz <= cfg.normal_z * a_ez;
      b_ray <= a_ray;
      // C: numerator sum
      c_num <= NUM_W'(b_pnx) + NUM_W'(b_pny) + NUM_W'(b_pnz);
      c_den <= b_den;
      c_ray <= b_ray;
      // D: magnitudes, sign, edge-on (zero denominator always rejects)
      out.nmag   <= nabs;
      out.dmag   <= dabs;
      out.neg    <= c_num[NUM_W-1] ^ c_den[DEN_W-1];
      out.reject <= (c_den == '0) ||
                    (dabs < (DEN_W'(cfg.edge_epsilon) << FRAC_BITS));
      out.ray    <= c_ray;
    end
  end

endmodule

>>> rtl/core/rdi_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturation detected up front.
// Depends on rdi_pkg.
module rdi_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  rdi_pkg::dot_out_t in,
  output rdi_pkg::div_out_t out
);
  import rdi_pkg::*;

  typedef struct packed {
    logic             reject;
    logic             neg;
    logic             sat;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] dmag;
    logic [Q_W-1:0]   nlo;
    logic [Q_W-1:0]   q;
    ray_t             ray;
  } stage_t;

  logic [Q_W:0]     vld;
  stage_t           st  [Q_W+1];
  stage_t           nxt [Q_W+1];
  logic [DIVN_W-1:0] nfull;
  logic [DEN_W:0]   trial [Q_W+1];

  assign nfull = {in.nmag, {FRAC_BITS{1'b0}}};

  always_comb begin
    nxt[0].reject = in.reject;
    nxt[0].neg    = in.neg;
    // quotient reaches 2^31 exactly when n >= d * 2^(31-frac)
    nxt[0].sat    = SAT_W'(in.nmag) >= (SAT_W'(in.dmag) << (Q_W - FRAC_BITS));
    nxt[0].rem    = DEN_W'(nfull >> Q_W);
    nxt[0].dmag   = in.dmag;
    nxt[0].nlo    = nfull[Q_W-1:0];
    nxt[0].q      = '0;
    nxt[0].ray    = in.ray;
    trial[0]      = '0;
    for (int k = 1; k <= Q_W; k++) begin
      nxt[k]   = st[k-1];
      trial[k] = {st[k-1].rem, st[k-1].nlo[Q_W-1]};
      nxt[k].nlo = {st[k-1].nlo[Q_W-2:0], 1'b0};
      if (trial[k] >= {1'b0, st[k-1].dmag}) begin
        nxt[k].rem = DEN_W'(trial[k] - {1'b0, st[k-1].dmag});
        nxt[k].q   = {st[k-1].q[Q_W-2:0], 1'b1};
      end else begin
        nxt[k].rem = DEN_W'(trial[k]);
        nxt[k].q   = {st[k-1].q[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Q_W-1:0], in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= Q_W; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign out.valid  = vld[Q_W];
  assign out.reject = st[Q_W].reject;
  assign out.neg    = st[Q_W].neg;
  assign out.sat    = st[Q_W].sat;
  assign out.q      = st[Q_W].q;
  assign out.ray    = st[Q_W].ray;

endmodule

>>> rtl/core/rdi_hit.sv
// Back stages: signed saturated distance, range test, hit point offset, squared length test.
// Depends on rdi_pkg. Last stage is the output register.
module rdi_hit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  rdi_pkg::cfg_t             cfg,
  input  rdi_pkg::div_out_t         in,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic signed [rdi_pkg::COORD_W-1:0] out_best
);
  import rdi_pkg::*;

  localparam logic signed [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] DIST_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [H_W-1:0]     HLIM     = H_W'(64'sd1 <<< AX_W);

  logic [5:0]                v;
  logic                      e_rej, f_rej, g_rej, h_rej, i_ok, j_ok;
  logic signed [COORD_W-1:0] e_dist, f_dist, g_dist, h_dist, i_dist, j_dist;
  logic signed [COORD_W-1:0] e_best, f_best, g_best, h_best, i_best, j_best;
  ray_t                      e_ray, f_ray, g_ray;
  logic signed [P_W-1:0]     f_px, f_py, f_pz;
  logic signed [P_W-1:0]     g_tx, g_ty, g_tz;
  logic signed [H_W-1:0]     h_hx, h_hy, h_hz;
  logic [AX_W-1:0]           i_ax, i_ay, i_az;
  logic [SQ_W-1:0]           j_sx, j_sy, j_sz;
  logic signed [COORD_W-1:0] dist_sat;
  logic [SUM_W-1:0]          ssum;

  always_comb begin
    if (in.sat) begin
      dist_sat = in.neg ? DIST_MIN : DIST_MAX;
    end else if (in.neg) begin
      dist_sat = -COORD_W'({1'b0, in.q});
    end else begin
      dist_sat = COORD_W'({1'b0, in.q});
    end
    ssum = SUM_W'(j_sx) + SUM_W'(j_sy) + SUM_W'(j_sz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[4:0], in.valid};
      out_valid <= v[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // E: distance and limits
      e_dist <= dist_sat;
      e_rej  <= in.reject || (dist_sat < in.ray.near_limit) || (dist_sat > in.ray.best_in);
      e_best <= in.ray.best_in;
      e_ray  <= in.ray;
      // F: dist * dir
      f_px   <= e_dist * e_ray.dir_x;
      f_py   <= e_dist * e_ray.dir_y;
      f_pz   <= e_dist * e_ray.dir_z;
      f_rej  <= e_rej;
      f_dist <= e_dist;
      f_best <= e_best;
      f_ray  <= e_ray;
      // G: scale back, truncating toward zero
      g_tx   <= scale_down(f_px);
      g_ty   <= scale_down(f_py);
      g_tz   <= scale_down(f_pz);
      g_rej  <= f_rej;
      g_dist <= f_dist;
      g_best <= f_best;
      g_ray  <= f_ray;
      // H: offset of hit point from center
      h_hx   <= H_W'(g_ray.origin_x) + H_W'(g_tx) - H_W'(cfg.center_x);
      h_hy   <= H_W'(g_ray.origin_y) + H_W'(g_ty) - H_W'(cfg.center_y);
      h_hz   <= H_W'(g_ray.origin_z) + H_W'(g_tz) - H_W'(cfg.center_z);
      h_rej  <= g_rej;
      h_dist <= g_dist;
      h_best <= g_best;
      // I: magnitudes must stay below 2^31
      i_ax   <= h_hx[H_W-1] ? AX_W'(-h_hx) : AX_W'(h_hx);
      i_ay   <= h_hy[H_W-1] ? AX_W'(-h_hy) : AX_W'(h_hy);
      i_az   <= h_hz[H_W-1] ? AX_W'(-h_hz) : AX_W'(h_hz);
      i_ok   <= !h_rej &&
                (h_hx > -HLIM) && (h_hx < HLIM) &&
                (h_hy > -HLIM) && (h_hy < HLIM) &&
                (h_hz > -HLIM) && (h_hz < HLIM);
      i_dist <= h_dist;
      i_best <= h_best;
      // J: squares
      j_sx   <= SQ_W'(i_ax) * SQ_W'(i_ax);
      j_sy   <= SQ_W'(i_ay) * SQ_W'(i_ay);
      j_sz   <= SQ_W'(i_az) * SQ_W'(i_az);
      j_ok   <= i_ok;
      j_dist <= i_dist;
      j_best <= i_best;
      // K: radius test, output register
      out_hit  <= j_ok && (ssum <= SUM_W'(cfg.radius_sq));
      out_best <= (j_ok && (ssum <= SUM_W'(cfg.radius_sq))) ? j_dist : j_best;
    end
  end

endmodule

>>> rtl/core/ray_disc_intersect.sv
// Top level of the ray/disc intersection pipeline: config registers, stall control, stages.
// Depends on rdi_pkg, rdi_ray_if, rdi_res_if, rdi_cfg_if, rdi_dot, rdi_div, rdi_hit.
//
// Tests one ray per cycle against a disc set up through the configuration
// channel (center Q16.16, unit normal signed Q2.16, radius unsigned Q15.16,
// edge-on epsilon unsigned Q0.16). A ray is rejected as edge-on when |n.dir|
// is zero or below epsilon, otherwise the plane distance n.(c - o) / n.dir is
// formed (truncated, saturated to 32 bits) and checked against near_limit and
// best_distance_in; a hit needs the squared offset of the hit point from the
// center to be at most radius^2. Every ray gives exactly one result, in order:
// hit and the new best distance (the plane distance on a hit, else best_distance_in).
// Throughput is one ray per cycle. The pipeline is 4 dot-product stages, 32
// divider stages (a saturation check, then one quotient bit each for the
// 31-bit quotient) and 7 back-end stages ending in the output register. While
// a result is held by the sink the whole pipeline holds and ray.ready is low.
// Config writes are always accepted and take effect in the next cycle, radius
// after disc_radius and radius squared; write only while no rays are in flight.
module ray_disc_intersect (
  input logic    clk,
  input logic    rst,
  rdi_ray_if.sink   ray,
  rdi_res_if.source result,
  rdi_cfg_if.sink   cfg
);
  import rdi_pkg::*;

  cfg_t              cfg_q;
  logic [RAD_W-1:0]  disc_radius;
  ray_t              in_ray;
  dot_out_t          dot_out;
  div_out_t          div_out;
  logic              en;

  // global advance: pipeline moves unless the output register is stuck
  assign en        = !result.valid || result.ready;
  assign ray.ready = en;
  assign cfg.ready = 1'b1;

  assign in_ray.origin_x   = ray.origin_x;
  assign in_ray.origin_y   = ray.origin_y;
  assign in_ray.origin_z   = ray.origin_z;
  assign in_ray.dir_x      = ray.dir_x;
  assign in_ray.dir_y      = ray.dir_y;
  assign in_ray.dir_z      = ray.dir_z;
  assign in_ray.near_limit = ray.near_limit;
  assign in_ray.best_in    = ray.best_distance_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.center_x     <= '0;
      cfg_q.center_y     <= '0;
      cfg_q.center_z     <= '0;
      cfg_q.normal_x     <= '0;
      cfg_q.normal_y     <= '0;
      cfg_q.normal_z     <= NORM_W'(1 << FRAC_BITS);
      cfg_q.edge_epsilon <= EPS_W'(1);
      disc_radius        <= RAD_W'(1 << FRAC_BITS);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CENTER_X: cfg_q.center_x     <= cfg.data;
        REG_CENTER_Y: cfg_q.center_y     <= cfg.data;
        REG_CENTER_Z: cfg_q.center_z     <= cfg.data;
        REG_NORMAL_X: cfg_q.normal_x     <= cfg.data[NORM_W-1:0];
        REG_NORMAL_Y: cfg_q.normal_y     <= cfg.data[NORM_W-1:0];
        REG_NORMAL_Z: cfg_q.normal_z     <= cfg.data[NORM_W-1:0];
        REG_RADIUS:   disc_radius        <= cfg.data[RAD_W-1:0];
        REG_EPSILON:  cfg_q.edge_epsilon <= cfg.data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // radius squared kept registered so the final compare has no multiplier
  always_ff @(posedge clk) begin
    cfg_q.radius_sq <= SQ_W'(disc_radius) * SQ_W'(disc_radius);
  end

  rdi_dot u_dot (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg_q),
    .in_valid (ray.valid),
    .in_ray   (in_ray),
    .out      (dot_out)
  );

  rdi_div u_div (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .in  (dot_out),
    .out (div_out)
  );

  rdi_hit u_hit (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg_q),
    .in        (div_out),
    .out_valid (result.valid),
    .out_hit   (result.hit),
    .out_best  (result.best_distance_out)
  );

endmodule

>>> bench/ray_disc_intersect_tb.sv
// Self-checking bench for ray_disc_intersect: ray requests in, hit/distance results out.
// Depends on rdi_pkg, rdi_ray_if, rdi_res_if, rdi_cfg_if and the RTL top level.
module ray_disc_intersect_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rdi_pkg::*;

  localparam int LATENCY = 43;
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef struct {
    logic hit;
    logic signed [31:0] best;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rdi_ray_if ray_ch();
  rdi_res_if res_ch();
  rdi_cfg_if cfg_ch();

  ray_disc_intersect uut (
    .clk(clk), .rst(rst), .ray(ray_ch.sink), .result(res_ch.source), .cfg(cfg_ch.sink)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the disc registers, kept at the register widths.
  logic signed [31:0] disc_cx, disc_cy, disc_cz;
  logic signed [17:0] disc_nx, disc_ny, disc_nz;
  logic [30:0] disc_rad;
  logic [15:0] disc_eps;

  hit_rec_t hits_pending[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_sink = 1'b0;      // long sink hold-off request
  bit burst_mode = 1'b1;     // sender gaps enabled

  function automatic logic [127:0] mag128(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Quotient num*2^16/den truncated toward zero, saturated to 32 bits.
  function automatic logic signed [31:0] plane_dist(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
    logic [127:0] q;
    logic neg;
    neg = (num < 0) != (den < 0);
    q = (mag128(num) << FRAC_BITS) / mag128(den);
    if (neg) return (q >= 128'h8000_0000) ? Q_MIN : -$signed(q[31:0]);
    return (q > 128'h7fff_ffff) ? Q_MAX : q[31:0];
  endfunction

  function automatic logic signed [127:0] scaled_prod(input logic signed [127:0] a,
                                                       input logic signed [127:0] b);
    logic signed [127:0] p;
    p = a * b;
    return p < 0 ? -$signed(mag128(p) >> FRAC_BITS) : $signed(mag128(p) >> FRAC_BITS);
  endfunction

  function automatic hit_rec_t disc_hit(input ray_t r);
    hit_rec_t o;
    logic signed [127:0] den, num, hx, hy, hz, t_hit;
    logic [127:0] ax, ay, az, lim, rr;
    o.hit = 1'b0;
    o.best = r.best_in;
    den = 128'(disc_nx) * 128'(r.dir_x) + 128'(disc_ny) * 128'(r.dir_y)
        + 128'(disc_nz) * 128'(r.dir_z);
    if (den != 0 && mag128(den) >= (128'(disc_eps) << FRAC_BITS)) begin
      num = 128'(disc_nx) * (128'(disc_cx) - 128'(r.origin_x))
          + 128'(disc_ny) * (128'(disc_cy) - 128'(r.origin_y))
          + 128'(disc_nz) * (128'(disc_cz) - 128'(r.origin_z));
      t_hit = plane_dist(num, den);
      if (!(t_hit < 128'(r.near_limit) || t_hit > 128'(r.best_in))) begin
        hx = 128'(r.origin_x) + scaled_prod(t_hit, 128'(r.dir_x)) - 128'(disc_cx);
        hy = 128'(r.origin_y) + scaled_prod(t_hit, 128'(r.dir_y)) - 128'(disc_cy);
        hz = 128'(r.origin_z) + scaled_prod(t_hit, 128'(r.dir_z)) - 128'(disc_cz);
        ax = mag128(hx); ay = mag128(hy); az = mag128(hz);
        lim = 128'h8000_0000;
        rr = 128'(disc_rad) * 128'(disc_rad);
        if (ax < lim && ay < lim && az < lim && ax*ax + ay*ay + az*az <= rr) begin
          o.hit = 1'b1;
          o.best = t_hit[31:0];
        end
      end
    end
    return o;
  endfunction

  initial begin
    ray_ch.valid = 1'b0;
    ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
    ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
    ray_ch.near_limit = '0; ray_ch.best_distance_in = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  // Sink: stalls on its own duty pattern, plus the long hold-off when asked.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase = (phase + 1) % 64;
      if (hold_sink) res_ch.ready <= 1'b0;
      else if (phase < 20) res_ch.ready <= 1'b1;
      else if (phase < 40) res_ch.ready <= ($urandom_range(3) != 0);
      else res_ch.ready <= ($urandom_range(1) != 0);
    end
  end

  // Result checker against the oldest expected hit record.
  always @(posedge clk) begin
    hit_rec_t exp_rec;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (hits_pending.size() == 0) begin
        $error("result with nothing expected: hit=%0b best_distance_out=%0d",
               res_ch.hit, res_ch.best_distance_out);
        errors++;
      end else begin
        exp_rec = hits_pending.pop_front();
        if (res_ch.hit !== exp_rec.hit) begin
          $error("hit: expected %0b, got %0b", exp_rec.hit, res_ch.hit);
          errors++;
        end
        if (res_ch.best_distance_out !== exp_rec.best) begin
          $error("best_distance_out: expected %0d, got %0d",
                 exp_rec.best, res_ch.best_distance_out);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("ray_disc_intersect_tb: errors");
      $finish;
    end
  end

  // Send one ray request; valid stays high across back-to-back rays.
  task automatic send_ray(input ray_t r);
    int gap;
    ray_ch.valid <= 1'b1;
    ray_ch.origin_x <= r.origin_x; ray_ch.origin_y <= r.origin_y;
    ray_ch.origin_z <= r.origin_z; ray_ch.dir_x <= r.dir_x;
    ray_ch.dir_y <= r.dir_y; ray_ch.dir_z <= r.dir_z;
    ray_ch.near_limit <= r.near_limit; ray_ch.best_distance_in <= r.best_in;
    do @(posedge clk); while (!ray_ch.ready);
    hits_pending.push_back(disc_hit(r));
    // bursts: usually no gap, sometimes a random one
    if (burst_mode && $urandom_range(7) == 0) begin
      gap = $urandom_range(12, 1);
      ray_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_rays();
    ray_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_rays();
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_CENTER_X: disc_cx = val;
      REG_CENTER_Y: disc_cy = val;
      REG_CENTER_Z: disc_cz = val;
      REG_NORMAL_X: disc_nx = val[17:0];
      REG_NORMAL_Y: disc_ny = val[17:0];
      REG_NORMAL_Z: disc_nz = val[17:0];
      REG_RADIUS:   disc_rad = val[30:0];
      REG_EPSILON:  disc_eps = val[15:0];
      default: ;
    endcase
    @(posedge clk);  // radius square is registered
  endtask

  task automatic set_disc(input logic signed [31:0] cx, cy, cz,
                          input logic signed [17:0] nx, ny, nz,
                          input logic [30:0] rad, input logic [15:0] eps);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_NORMAL_X, 32'(nx));
    write_reg(REG_NORMAL_Y, 32'(ny));
    write_reg(REG_NORMAL_Z, 32'(nz));
    write_reg(REG_RADIUS, 32'(rad));
    write_reg(REG_EPSILON, 32'(eps));
  endtask

  function automatic logic signed [31:0] rnd_small(input int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic signed [31:0] rnd_any();
    return $urandom();
  endfunction

  // Ray aimed through a point near the disc center so many rays hit.
  function automatic ray_t aimed_ray();
    ray_t r;
    logic signed [31:0] tx, ty, tz, rad_span;
    rad_span = (disc_rad > 31'd1000000) ? 32'sd1000000 : 32'(disc_rad) + 2;
    tx = disc_cx + rnd_small(rad_span);
    ty = disc_cy + rnd_small(rad_span);
    tz = disc_cz + rnd_small(rad_span);
    r.dir_x = rnd_small(3 * 65536);
    r.dir_y = rnd_small(3 * 65536);
    r.dir_z = rnd_small(3 * 65536);
    // origin = target - k*dir, with its own k in [1,4] for each axis
    r.origin_x = tx - r.dir_x * $signed($urandom_range(4, 1));
    r.origin_y = ty - r.dir_y * $signed($urandom_range(4, 1));
    r.origin_z = tz - r.dir_z * $signed($urandom_range(4, 1));
    r.near_limit = ($urandom_range(3) == 0) ? rnd_any() : rnd_small(65536);
    r.best_in = ($urandom_range(3) == 0) ? rnd_any() : Q_MAX - $urandom_range(65536);
    return r;
  endfunction

  function automatic ray_t noise_ray();
    ray_t r;
    r.origin_x = rnd_any(); r.origin_y = rnd_any(); r.origin_z = rnd_any();
    r.dir_x = rnd_any(); r.dir_y = rnd_any(); r.dir_z = rnd_any();
    r.near_limit = rnd_any(); r.best_in = rnd_any();
    return r;
  endfunction

  function automatic ray_t mk_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz,
                                  input logic signed [31:0] nearv, best);
    ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.near_limit = nearv; r.best_in = best;
    return r;
  endfunction

  // Directed rays against the reset disc (unit disc in the z=0 plane), then against two other discs.
  task automatic test_directed();
    send_ray(mk_ray(0, 0, 5 * Q_ONE, 0, 0, -Q_ONE, 0, Q_MAX));        // straight hit
    send_ray(mk_ray(2 * Q_ONE, 0, Q_ONE, 0, 0, -Q_ONE, 0, Q_MAX));    // outside radius
    send_ray(mk_ray(Q_ONE, 0, Q_ONE, 0, 0, -Q_ONE, 0, Q_MAX));        // on the rim
    send_ray(mk_ray(0, 0, Q_ONE, Q_ONE, 0, 0, 0, Q_MAX));             // parallel: zero den
    send_ray(mk_ray(0, 0, Q_ONE, Q_ONE, 0, 0, Q_MIN, Q_MAX));
    send_ray(mk_ray(0, 0, 5 * Q_ONE, 0, 0, -Q_ONE, 6 * Q_ONE, Q_MAX)); // below near
    send_ray(mk_ray(0, 0, 5 * Q_ONE, 0, 0, -Q_ONE, 0, 4 * Q_ONE));    // beyond best
    send_ray(mk_ray(0, 0, 5 * Q_ONE, 0, 0, -Q_ONE, 5 * Q_ONE, 5 * Q_ONE)); // exact limits
    send_ray(mk_ray(0, 0, -Q_ONE, 0, 0, -Q_ONE, Q_MIN, Q_MAX));       // behind: negative
    send_ray(mk_ray(0, 0, Q_MAX, 0, 0, -1, 0, Q_MAX));                // saturated quotient
    send_ray(mk_ray(0, 0, Q_MIN, 0, 0, -1, Q_MIN, Q_MAX));            // negative saturation
    send_ray(mk_ray(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX));
    send_ray(mk_ray(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_ray(mk_ray(0, 0, 3, 0, 0, -1, 0, Q_MAX));                    // den right at eps
    send_ray(mk_ray(-1, -1, -1, -1, -1, -1, -1, -1));
    drain();
    // zero epsilon, zero normal: every den is zero
    set_disc(0, 0, 0, 0, 0, 0, 0, 0);
    send_ray(mk_ray(0, 0, Q_ONE, 0, 0, -Q_ONE, Q_MIN, Q_MAX));
    send_ray(mk_ray(Q_ONE, 7, 3, 1, 1, 1, Q_MIN, Q_MAX));
    drain();
    // full epsilon, negative full normal, huge radius
    set_disc(Q_MAX, Q_MIN, Q_ONE, -18'sd65536, 0, 0, 31'h7fffffff, 16'hffff);
    send_ray(mk_ray(0, Q_MIN, Q_ONE, Q_ONE, 0, 0, Q_MIN, Q_MAX));
    send_ray(mk_ray(0, Q_MIN, Q_ONE, 32'sh7fff0000, 0, 0, Q_MIN, Q_MAX));
    send_ray(mk_ray(0, 0, 0, -Q_MAX, 5, 9, Q_MIN, Q_MAX));
    drain();
  endtask

  // Random rays against one random disc setting.
  task automatic test_random(input int count);
    ray_t r;
    set_disc(rnd_small(50 * 65536), rnd_small(50 * 65536), rnd_small(50 * 65536),
             $signed(18'($urandom_range(131072))) - 18'sd65536,
             $signed(18'($urandom_range(131072))) - 18'sd65536,
             $signed(18'($urandom_range(131072))) - 18'sd65536,
             ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(8 * 65536)),
             ($urandom_range(1) == 0) ? 16'($urandom()) : 16'($urandom_range(8)));
    for (int i = 0; i < count; i++) begin
      r = ($urandom_range(4) == 0) ? noise_ray() : aimed_ray();
      send_ray(r);
    end
    drain();
  endtask

  // Sink holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    ray_t r;
    burst_mode = 1'b0;
    fork
      begin
        hold_sink = 1'b1;
        repeat (LATENCY * 3) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 80; i++) begin
        r = aimed_ray();
        send_ray(r);
      end
    join
    burst_mode = 1'b1;
    drain();
  endtask

  initial begin
    disc_cx = 0; disc_cy = 0; disc_cz = 0;
    disc_nx = 0; disc_ny = 0; disc_nz = 18'sd65536;
    disc_rad = 31'd65536; disc_eps = 16'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 6; p++) test_random(75);
    test_backpressure();
    // unit normal on x, tight epsilon; rays from random points near the plane
    set_disc(0, 0, 0, 18'sd65536, 0, 0, 31'd1, 16'd0);
    for (int i = 0; i < 10; i++) send_ray(aimed_ray());
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0)
      $display("ray_disc_intersect_tb: clean");
    else
      $display("ray_disc_intersect_tb: errors");
    $finish;
  end

endmodule
